[hw/rtl/assert_macros.svh]
// Assertion macros shared by the clipped blitter RTL.
// Needs signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/cbf_pkg.sv]
// Types, constants and helper functions of the clipped blitter.
// Used by cbf_engine and clipped_blit_fill_color_key; no dependencies.
package cbf_pkg;

   localparam int COORD_BITS   = 16;
   localparam int PIXEL_BITS   = 32;
   localparam int ADDR_BITS    = 32;
   localparam int KEY_BITS     = 32;
   localparam int FRAME_BITS   = 13;
   localparam int BPP_BITS     = 3;
   localparam int STRIDE_BITS  = FRAME_BITS + 2;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int POS_BITS     = COORD_BITS + 2;
   localparam int PROD_BITS    = STRIDE_BITS + 1 + COORD_BITS;

   localparam logic [FRAME_BITS-1:0]  RESET_FRAME_WIDTH  = FRAME_BITS'(1024);
   localparam logic [FRAME_BITS-1:0]  RESET_FRAME_HEIGHT = FRAME_BITS'(768);
   localparam logic [BPP_BITS-1:0]    RESET_BPP          = BPP_BITS'(4);
   localparam logic [STRIDE_BITS-1:0] RESET_STRIDE       = STRIDE_BITS'(4096);

   typedef enum logic [1:0] {
      OP_FILL  = 2'd0,
      OP_COPY  = 2'd1,
      OP_KEYED = 2'd2,
      OP_PIXEL = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_BPP          = 3'd2,
      REG_FRAME_BASE   = 3'd3,
      REG_KEY_COLOR    = 3'd4
   } reg_type;

   typedef struct packed {
      op_type                  opcode;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic [COORD_BITS-1:0]   rect_width;
      logic [COORD_BITS-1:0]   rect_height;
      logic [PIXEL_BITS-1:0]   pixel_value;
   } req_type;

   typedef struct packed {
      logic                  write_enable;
      logic [ADDR_BITS-1:0]  write_address;
      logic [PIXEL_BITS-1:0] write_data;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0]  frame_width;
      logic [FRAME_BITS-1:0]  frame_height;
      logic [BPP_BITS-1:0]    bpp;
      logic [STRIDE_BITS-1:0] stride;
      logic [ADDR_BITS-1:0]   frame_base;
      logic [KEY_BITS-1:0]    key_color;
   } cfg_type;

   function automatic logic [BPP_BITS-1:0] eff_bpp(input logic [BPP_BITS-1:0] raw);
      logic [BPP_BITS-1:0] res;
      case (raw) inside
         3'd0:          res = 3'd1;
         [3'd1:3'd4]:   res = raw;
         default:       res = 3'd4;
      endcase
      return res;
   endfunction

   function automatic logic [STRIDE_BITS-1:0] stride_of(input logic [BPP_BITS-1:0] bpp,
                                                         input logic [FRAME_BITS-1:0] fw);
      return STRIDE_BITS'(STRIDE_BITS'(bpp) * STRIDE_BITS'(fw));
   endfunction

   function automatic logic [KEY_BITS-1:0] byte_mask(input logic [BPP_BITS-1:0] bpp);
      logic [KEY_BITS-1:0] res;
      case (bpp)
         3'd1:    res = 32'h0000_00FF;
         3'd2:    res = 32'h0000_FFFF;
         3'd3:    res = 32'h00FF_FFFF;
         default: res = 32'hFFFF_FFFF;
      endcase
      return res;
   endfunction

   function automatic logic [ADDR_BITS-1:0] scale_by_bpp(input logic [BPP_BITS-1:0] bpp,
                                                          input logic [ADDR_BITS-1:0] v);
      logic [ADDR_BITS-1:0] res;
      case (bpp)
         3'd1:    res = v;
         3'd2:    res = v << 1;
         3'd3:    res = v + (v << 1);
         default: res = v << 2;
      endcase
      return res;
   endfunction

endpackage

[hw/rtl/clipped_blit_fill_color_key.sv]
// Clipped 2D blitter: fill, copy and color-keyed copy into a linear frame buffer.
// Depends on cbf_pkg, cbf_engine and assert_macros.svh.
//
// Usage:
//   csr_*  : register writes (index, data), always ready; write only while idle.
//   req_*  : one request per cycle unless stalled. Opcodes fill, copy or keyed
//            copy start a rectangle; pixel advances one position in raster order.
//   rsp_*  : exactly one response per request: a frame buffer write when the
//            position is inside the frame (and not keyed out), plus last.
// Response: registered, into the output register or the skid buffer if blocked.
// Throughput: 1 request per cycle while req_stall is low; the raster position
//   update and the row start multiply both finish in the accept cycle.
// Stall: the response register plus a one-entry skid buffer let a request be
//   accepted while a response waits; req_stall rises once the skid holds data
//   and falls the cycle after rsp_stall releases.
// Reset: synchronous, active high; registers return to 1024x768, 4 bytes per
//   pixel, base and key zero; the engine goes idle and no response is held.
`include "assert_macros.svh"

module clipped_blit_fill_color_key (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_opcode,
   input  logic signed [cbf_pkg::COORD_BITS-1:0] req_pos_x,
   input  logic signed [cbf_pkg::COORD_BITS-1:0] req_pos_y,
   input  logic [cbf_pkg::COORD_BITS-1:0]        req_rect_width,
   input  logic [cbf_pkg::COORD_BITS-1:0]        req_rect_height,
   input  logic [cbf_pkg::PIXEL_BITS-1:0]        req_pixel_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_write_enable,
   output logic [cbf_pkg::ADDR_BITS-1:0]         rsp_write_address,
   output logic [cbf_pkg::PIXEL_BITS-1:0]        rsp_write_data,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cbf_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [cbf_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   logic [cbf_pkg::FRAME_BITS-1:0]  fw_ff;
   logic [cbf_pkg::FRAME_BITS-1:0]  fh_ff;
   logic [cbf_pkg::BPP_BITS-1:0]    bpp_ff;
   logic [cbf_pkg::STRIDE_BITS-1:0] stride_ff;
   logic [cbf_pkg::ADDR_BITS-1:0]   base_ff;
   logic [cbf_pkg::KEY_BITS-1:0]    key_ff;
   logic [cbf_pkg::BPP_BITS-1:0]    new_bpp;
   logic                            csr_write;

   cbf_pkg::req_type req;
   cbf_pkg::cfg_type cfg;
   cbf_pkg::rsp_type result;
   cbf_pkg::rsp_type out_ff, out_in;
   cbf_pkg::rsp_type skid_ff, skid_in;
   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic             req_accept;
   logic             out_take;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign new_bpp   = cbf_pkg::eff_bpp(csr_wdata[cbf_pkg::BPP_BITS-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff     <= cbf_pkg::RESET_FRAME_WIDTH;
         fh_ff     <= cbf_pkg::RESET_FRAME_HEIGHT;
         bpp_ff    <= cbf_pkg::RESET_BPP;
         stride_ff <= cbf_pkg::RESET_STRIDE;
         base_ff   <= '0;
         key_ff    <= '0;
      end else if (csr_write) begin
         unique case (cbf_pkg::reg_type'(csr_index))
            cbf_pkg::REG_FRAME_WIDTH: begin
               fw_ff     <= csr_wdata[cbf_pkg::FRAME_BITS-1:0];
               stride_ff <= cbf_pkg::stride_of(bpp_ff, csr_wdata[cbf_pkg::FRAME_BITS-1:0]);
            end
            cbf_pkg::REG_FRAME_HEIGHT: fh_ff <= csr_wdata[cbf_pkg::FRAME_BITS-1:0];
            cbf_pkg::REG_BPP: begin
               bpp_ff    <= new_bpp;
               stride_ff <= cbf_pkg::stride_of(new_bpp, fw_ff);
            end
            cbf_pkg::REG_FRAME_BASE: base_ff <= csr_wdata[cbf_pkg::ADDR_BITS-1:0];
            cbf_pkg::REG_KEY_COLOR:  key_ff  <= csr_wdata[cbf_pkg::KEY_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.frame_width  = fw_ff;
      cfg.frame_height = fh_ff;
      cfg.bpp          = bpp_ff;
      cfg.stride       = stride_ff;
      cfg.frame_base   = base_ff;
      cfg.key_color    = key_ff;
      req.opcode       = cbf_pkg::op_type'(req_opcode);
      req.pos_x        = req_pos_x;
      req.pos_y        = req_pos_y;
      req.rect_width   = req_rect_width;
      req.rect_height  = req_rect_height;
      req.pixel_value  = req_pixel_value;
   end

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign out_take   = out_valid_ff && !rsp_stall;

   cbf_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req        (req),
      .cfg        (cfg),
      .result     (result)
   );

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff && !out_take;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         out_valid_in = 1'b1;
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         out_valid_in = 1'b1;
         if (!out_valid_ff || out_take) begin
            out_in = result;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_enable  = out_ff.write_enable;
   assign rsp_write_address = out_ff.write_address;
   assign rsp_write_data    = out_ff.write_data;
   assign rsp_last          = out_ff.last;

   `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_ff || out_valid_ff, "skid holds data while output is empty")
   `ASSERT_ALWAYS(a_no_write_zero, !out_valid_ff || out_ff.write_enable || (out_ff.write_address == '0 && out_ff.write_data == '0), "response without write carries data")
   `ASSERT_NEXT(a_skid_fill_on_block, req_accept && out_valid_ff && rsp_stall && !skid_valid_ff, skid_valid_ff, "accepted request lost while output blocked")

endmodule

[hw/rtl/cbf_engine.sv]
// Raster walk of the clipped blitter: rectangle state, clipping, key test.
// Depends on cbf_pkg and assert_macros.svh; one request handled per cycle while req_accept is high.
`include "assert_macros.svh"

module cbf_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_accept,
   input  cbf_pkg::req_type req,
   input  cbf_pkg::cfg_type cfg,
   output cbf_pkg::rsp_type result
);

   cbf_pkg::op_type                      mode_ff, mode_in;
   logic                                 active_ff, active_in;
   logic signed [cbf_pkg::COORD_BITS-1:0] origin_x_ff, origin_x_in;
   logic signed [cbf_pkg::COORD_BITS-1:0] origin_y_ff, origin_y_in;
   logic [cbf_pkg::COORD_BITS-1:0]       span_w_ff, span_w_in;
   logic [cbf_pkg::COORD_BITS-1:0]       span_h_ff, span_h_in;
   logic [cbf_pkg::COORD_BITS-1:0]       column_ff, column_in;
   logic [cbf_pkg::COORD_BITS-1:0]       row_ff, row_in;
   logic [cbf_pkg::PIXEL_BITS-1:0]       fill_ff, fill_in;
   logic [cbf_pkg::ADDR_BITS-1:0]        line_ff, line_in;

   logic signed [cbf_pkg::PROD_BITS-1:0] start_offset;
   logic [cbf_pkg::ADDR_BITS-1:0]        line_start;
   logic signed [cbf_pkg::POS_BITS-1:0]  x_pos;
   logic signed [cbf_pkg::POS_BITS-1:0]  y_pos;
   logic                                 inside_x;
   logic                                 inside_y;
   logic [cbf_pkg::KEY_BITS-1:0]         kmask;
   logic                                 key_hit;
   logic [cbf_pkg::PIXEL_BITS-1:0]       color;
   logic [cbf_pkg::ADDR_BITS-1:0]        pixel_addr;
   logic                                 col_end;
   logic                                 is_last;
   logic [cbf_pkg::COORD_BITS:0]         col_p1;
   logic                                 is_start;

   assign is_start = (req.opcode != cbf_pkg::OP_PIXEL);

   assign start_offset = cbf_pkg::PROD_BITS'($signed({1'b0, cfg.stride})) *
                         cbf_pkg::PROD_BITS'(req.pos_y);
   assign line_start   = cfg.frame_base + cbf_pkg::ADDR_BITS'(start_offset);

   assign x_pos = $signed({{2{origin_x_ff[cbf_pkg::COORD_BITS-1]}}, origin_x_ff}) +
                  $signed({2'b00, column_ff});
   assign y_pos = $signed({{2{origin_y_ff[cbf_pkg::COORD_BITS-1]}}, origin_y_ff}) +
                  $signed({2'b00, row_ff});

   assign inside_x = !x_pos[cbf_pkg::POS_BITS-1] &&
      (x_pos[cbf_pkg::POS_BITS-2:0] < (cbf_pkg::POS_BITS-1)'(cfg.frame_width));
   assign inside_y = !y_pos[cbf_pkg::POS_BITS-1] &&
      (y_pos[cbf_pkg::POS_BITS-2:0] < (cbf_pkg::POS_BITS-1)'(cfg.frame_height));

   assign kmask   = cbf_pkg::byte_mask(cfg.bpp);
   assign key_hit = (((cbf_pkg::KEY_BITS'(req.pixel_value)) ^ cfg.key_color) & kmask) == '0;
   assign color   = ((mode_ff == cbf_pkg::OP_FILL) ? fill_ff : req.pixel_value) &
                    cbf_pkg::PIXEL_BITS'(kmask);
   assign pixel_addr = line_ff + cbf_pkg::scale_by_bpp(cfg.bpp, cbf_pkg::ADDR_BITS'(x_pos));

   assign col_p1  = (cbf_pkg::COORD_BITS+1)'(column_ff) + (cbf_pkg::COORD_BITS+1)'(1);
   assign col_end = (col_p1 >= {1'b0, span_w_ff});
   assign is_last = (column_ff == span_w_ff - cbf_pkg::COORD_BITS'(1)) &&
                    (row_ff == span_h_ff - cbf_pkg::COORD_BITS'(1));

   always_comb begin
      mode_in     = mode_ff;
      active_in   = active_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      span_w_in   = span_w_ff;
      span_h_in   = span_h_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      fill_in     = fill_ff;
      line_in     = line_ff;
      result      = '0;
      if (is_start) begin
         mode_in     = req.opcode;
         origin_x_in = req.pos_x;
         origin_y_in = req.pos_y;
         span_w_in   = req.rect_width;
         span_h_in   = req.rect_height;
         fill_in     = req.pixel_value;
         column_in   = '0;
         row_in      = '0;
         line_in     = line_start;
         active_in   = (req.rect_width != '0) && (req.rect_height != '0);
         result.last = !active_in;
      end else if (active_ff) begin
         if (inside_x && inside_y && !((mode_ff == cbf_pkg::OP_KEYED) && key_hit)) begin
            result.write_enable  = 1'b1;
            result.write_address = pixel_addr;
            result.write_data    = color;
         end
         result.last = is_last;
         if (is_last) begin
            active_in = 1'b0;
            column_in = '0;
            row_in    = '0;
         end else if (col_end) begin
            column_in = '0;
            row_in    = row_ff + cbf_pkg::COORD_BITS'(1);
            line_in   = line_ff + cbf_pkg::ADDR_BITS'(cfg.stride);
         end else begin
            column_in = col_p1[cbf_pkg::COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= cbf_pkg::OP_FILL;
         active_ff <= 1'b0;
         column_ff <= '0;
         row_ff    <= '0;
      end else if (req_accept) begin
         mode_ff   <= mode_in;
         active_ff <= active_in;
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         span_w_ff   <= span_w_in;
         span_h_ff   <= span_h_in;
         fill_ff     <= fill_in;
         line_ff     <= line_in;
      end
   end

   `ASSERT_ALWAYS(a_idle_counters_clear, active_ff || (column_ff == '0 && row_ff == '0), "idle engine with nonzero position")
   `ASSERT_NEXT(a_empty_start_idle, req_accept && is_start && req.rect_width == '0, !active_ff, "empty rectangle left engine active")
   `ASSERT_ALWAYS(a_last_ends_walk, !(req_accept && !is_start && active_ff && is_last) || !active_in, "last position did not end walk")

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for clipped_blit_fill_color_key: a directed table, then random
// rectangles under several frame settings, each response checked against the table or a local predictor.
// Depends on cbf_pkg and the blitter RTL only.
module testbench;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 52;

   typedef struct {
      cbf_pkg::req_type rq;
      bit               typed;
      cbf_pkg::rsp_type rsp;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid       = 1'b0;
   logic                                  req_stall;
   logic [1:0]                            req_opcode      = cbf_pkg::OP_FILL;
   logic signed [cbf_pkg::COORD_BITS-1:0] req_pos_x       = '0;
   logic signed [cbf_pkg::COORD_BITS-1:0] req_pos_y       = '0;
   logic [cbf_pkg::COORD_BITS-1:0]        req_rect_width  = '0;
   logic [cbf_pkg::COORD_BITS-1:0]        req_rect_height = '0;
   logic [cbf_pkg::PIXEL_BITS-1:0]        req_pixel_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall       = 1'b0;
   logic                                  rsp_write_enable;
   logic [cbf_pkg::ADDR_BITS-1:0]         rsp_write_address;
   logic [cbf_pkg::PIXEL_BITS-1:0]        rsp_write_data;
   logic                                  rsp_last;
   logic                                  csr_valid       = 1'b0;
   logic                                  csr_ready;
   logic [cbf_pkg::CSR_IDX_BITS-1:0]      csr_index       = cbf_pkg::REG_FRAME_WIDTH;
   logic [cbf_pkg::CSR_DATA_BITS-1:0]     csr_wdata       = '0;

   cbf_pkg::rsp_type pending_writes [$];
   int unsigned      mismatches  = 0;
   int unsigned      cycle_count = 0;
   int unsigned      idle_mode   = 2;
   int unsigned      stall_left  = 0;

   logic [cbf_pkg::FRAME_BITS-1:0] frame_w   = 13'd1024;
   logic [cbf_pkg::FRAME_BITS-1:0] frame_h   = 13'd768;
   logic [cbf_pkg::BPP_BITS-1:0]   bpp_raw   = 3'd4;
   logic [cbf_pkg::ADDR_BITS-1:0]  base_addr = '0;
   logic [cbf_pkg::KEY_BITS-1:0]   key       = '0;

   cbf_pkg::op_type                       draw_op    = cbf_pkg::OP_FILL;
   bit                                    drawing    = 1'b0;
   logic signed [cbf_pkg::COORD_BITS-1:0] org_x      = '0;
   logic signed [cbf_pkg::COORD_BITS-1:0] org_y      = '0;
   logic [cbf_pkg::COORD_BITS-1:0]        span_w     = '0;
   logic [cbf_pkg::COORD_BITS-1:0]        span_h     = '0;
   int unsigned                           cur_col    = 0;
   int unsigned                           cur_row    = 0;
   logic [cbf_pkg::PIXEL_BITS-1:0]        fill_color = '0;
   logic [cbf_pkg::ADDR_BITS-1:0]         row_addr   = '0;

   clipped_blit_fill_color_key u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_rect_width    (req_rect_width),
      .req_rect_height   (req_rect_height),
      .req_pixel_value   (req_pixel_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned pixel_bytes();
      if (bpp_raw == 3'd0) return 1;
      if (bpp_raw > 3'd4) return 4;
      return 32'(bpp_raw);
   endfunction

   function automatic logic [31:0] color_mask();
      return 32'((64'd1 << (8 * pixel_bytes())) - 64'd1);
   endfunction

   function automatic cbf_pkg::rsp_type predict_blit_write(input cbf_pkg::req_type rq);
      cbf_pkg::rsp_type res;
      logic [31:0]      stride;
      logic [31:0]      color;
      longint           px;
      longint           py;
      bit               in_frame;
      bit               at_end;
      res    = '0;
      stride = pixel_bytes() * frame_w;
      if (rq.opcode != cbf_pkg::OP_PIXEL) begin
         draw_op    = rq.opcode;
         org_x      = rq.pos_x;
         org_y      = rq.pos_y;
         span_w     = rq.rect_width;
         span_h     = rq.rect_height;
         fill_color = rq.pixel_value;
         cur_col    = 0;
         cur_row    = 0;
         row_addr   = base_addr + stride * unsigned'(int'(org_y));
         drawing    = span_w != 0 && span_h != 0;
         res.last   = !drawing;
         return res;
      end
      if (!drawing) return res;
      px = longint'(org_x) + longint'(cur_col);
      py = longint'(org_y) + longint'(cur_row);
      in_frame = px >= 0 && px < longint'(frame_w) && py >= 0 && py < longint'(frame_h);
      color  = (draw_op == cbf_pkg::OP_FILL) ? fill_color : rq.pixel_value;
      at_end = cur_col == span_w - 1 && cur_row == span_h - 1;
      if (draw_op == cbf_pkg::OP_KEYED &&
          (rq.pixel_value & color_mask()) == (key & color_mask()))
         in_frame = 1'b0;
      if (in_frame) begin
         res.write_enable  = 1'b1;
         res.write_address = row_addr + pixel_bytes() * px[31:0];
         res.write_data    = color & color_mask();
      end
      res.last = at_end;
      cur_col++;
      if (cur_col >= span_w) begin
         cur_col = 0;
         cur_row++;
         row_addr += stride;
      end
      if (at_end) begin
         drawing = 1'b0;
         cur_col = 0;
         cur_row = 0;
      end
      return res;
   endfunction

   function automatic cbf_pkg::req_type make_req(input cbf_pkg::op_type op,
                                                 input logic [15:0] x, y, w, h,
                                                 input logic [31:0] pix);
      cbf_pkg::req_type rq;
      rq.opcode      = op;
      rq.pos_x       = signed'(x);
      rq.pos_y       = signed'(y);
      rq.rect_width  = w;
      rq.rect_height = h;
      rq.pixel_value = pix;
      return rq;
   endfunction

   function automatic plan_row_type plan_entry(input cbf_pkg::op_type op, input int x, y, w, h,
                                               input logic [31:0] pix, input bit typed,
                                               input bit we, input logic [31:0] addr, data,
                                               input bit last);
      plan_row_type pr;
      pr.rq                = make_req(op, 16'(x), 16'(y), 16'(w), 16'(h), pix);
      pr.typed             = typed;
      pr.rsp.write_enable  = we;
      pr.rsp.write_address = addr;
      pr.rsp.write_data    = data;
      pr.rsp.last          = last;
      return pr;
   endfunction

   function automatic logic [15:0] pick_origin(input int extent);
      case ($urandom_range(0, 2))
         0:       return 16'(int'($urandom_range(0, 8)) - 4);
         1:       return 16'(extent - int'($urandom_range(0, 6)));
         default: return 16'($urandom_range(0, extent));
      endcase
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned roll;
      if (idle_mode == 0) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93 || idle_mode == 1) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_request(input cbf_pkg::req_type rq, input bit typed,
                               input cbf_pkg::rsp_type typed_rsp);
      int unsigned      gap;
      cbf_pkg::rsp_type predicted;
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= rq.opcode;
      req_pos_x       <= rq.pos_x;
      req_pos_y       <= rq.pos_y;
      req_rect_width  <= rq.rect_width;
      req_rect_height <= rq.rect_height;
      req_pixel_value <= rq.pixel_value;
      do @(posedge clock); while (req_stall);
      predicted = predict_blit_write(rq);
      pending_writes.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_frame(input int phase);
      logic [31:0]      vals [5];
      cbf_pkg::reg_type r;
      case (phase)
         0: vals = '{32'd16, 32'd12, 32'd1, $urandom, 32'h5A};
         1: vals = '{32'd1, 32'd1, 32'd2, $urandom, $urandom};
         2: vals = '{32'd0, 32'd10, 32'd3, $urandom, $urandom};
         3: vals = '{32'd10, 32'd0, 32'd0, $urandom, $urandom};
         4: vals = '{32'd4096, 32'd4096, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
         5: vals = '{32'd8191, 32'd8191, 32'd7, 32'h0, 32'h0};
         6: vals = '{32'd20, 32'd20, 32'd5, 32'hFFFF_F000, $urandom};
         default: begin
            vals = '{$urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(0, 7),
                     $urandom, $urandom};
            if (phase % 2 == 1) begin
               vals[cbf_pkg::REG_FRAME_WIDTH]  |= $urandom & 32'hFFFF_E000;
               vals[cbf_pkg::REG_FRAME_HEIGHT] |= $urandom & 32'hFFFF_E000;
               vals[cbf_pkg::REG_BPP]          |= $urandom & 32'hFFFF_FFF8;
            end
         end
      endcase
      r = r.first();
      do begin
         csr_valid <= 1'b1;
         csr_index <= r;
         csr_wdata <= vals[r];
         do @(posedge clock); while (!csr_ready);
         case (r)
            cbf_pkg::REG_FRAME_WIDTH:  frame_w   = vals[r][cbf_pkg::FRAME_BITS-1:0];
            cbf_pkg::REG_FRAME_HEIGHT: frame_h   = vals[r][cbf_pkg::FRAME_BITS-1:0];
            cbf_pkg::REG_BPP:          bpp_raw   = vals[r][cbf_pkg::BPP_BITS-1:0];
            cbf_pkg::REG_FRAME_BASE:   base_addr = vals[r];
            cbf_pkg::REG_KEY_COLOR:    key       = vals[r];
            default: ;
         endcase
         r = r.next();
      end while (r != r.first());
      csr_valid <= 1'b0;
   endtask

   task automatic draw_random(input int unsigned budget);
      int unsigned     sent;
      int unsigned     count;
      int unsigned     roll;
      cbf_pkg::op_type op;
      logic [15:0]     w;
      logic [15:0]     h;
      logic [31:0]     pix;
      sent = 0;
      while (sent < budget) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            if (drawing) sent++;
            send_request(make_req(cbf_pkg::OP_PIXEL, 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), $urandom), 1'b0, '0);
         end else if (roll < 14) begin
            op = cbf_pkg::op_type'($urandom_range(0, 2));
            send_request(make_req(op, 16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), $urandom), 1'b0, '0);
            count = $urandom_range(0, 3);
            repeat (count)
               send_request(make_req(cbf_pkg::OP_PIXEL, 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom), $urandom), 1'b0, '0);
            sent += 1 + count;
         end else begin
            op = cbf_pkg::op_type'($urandom_range(0, 2));
            w  = 16'($urandom_range(1, 8));
            h  = 16'($urandom_range(1, 6));
            send_request(make_req(op, pick_origin(frame_w), pick_origin(frame_h), w, h,
                                  $urandom), 1'b0, '0);
            count = w * h;
            if ($urandom_range(0, 9) == 0) count = $urandom_range(0, count - 1);
            repeat (count) begin
               pix = $urandom;
               if (op == cbf_pkg::OP_KEYED && $urandom_range(0, 9) < 4)
                  pix = (key & color_mask()) | (pix & ~color_mask());
               send_request(make_req(cbf_pkg::OP_PIXEL, 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom), pix), 1'b0, '0);
            end
            sent += 1 + count;
         end
      end
      if (drawing)
         send_request(make_req(cbf_pkg::OP_FILL, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0),
                      1'b0, '0);
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         stall_left <= idle_gap();
         rsp_stall  <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_writes
      cbf_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_write_enable !== want.write_enable) begin
               $error("write_enable: expected %0b, actual %0b",
                      want.write_enable, rsp_write_enable);
               mismatches++;
            end
            if (rsp_write_address !== want.write_address) begin
               $error("write_address: expected %h, actual %h",
                      want.write_address, rsp_write_address);
               mismatches++;
            end
            if (rsp_write_data !== want.write_data) begin
               $error("write_data: expected %h, actual %h", want.write_data, rsp_write_data);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type plan [$];
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h0, 1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_FILL, 0, 0, 0, 5, 32'h1, 1, 0, 0, 0, 1));
      plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h7, 1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_COPY, 0, 0, 3, 0, 32'h0, 1, 0, 0, 0, 1));
      plan.push_back(plan_entry(cbf_pkg::OP_FILL, 0, 0, 1, 1, 32'hFFFF_FFFF,
                                1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h1234_5678,
                                1, 1, 32'h0, 32'hFFFF_FFFF, 1));
      plan.push_back(plan_entry(cbf_pkg::OP_FILL, 1023, 767, 1, 1, 32'hA5A5_A5A5,
                                1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h0,
                                1, 1, 32'h002F_FFFC, 32'hA5A5_A5A5, 1));
      plan.push_back(plan_entry(cbf_pkg::OP_COPY, -1, 0, 2, 1, 32'h0, 1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h11, 1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h22,
                                1, 1, 32'h0, 32'h22, 1));
      plan.push_back(plan_entry(cbf_pkg::OP_KEYED, 0, 0, 2, 1, 32'h0, 1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h0, 1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, 32'hDEAD_BEEF,
                                1, 1, 32'h4, 32'hDEAD_BEEF, 1));
      plan.push_back(plan_entry(cbf_pkg::OP_COPY, 32767, 32767, 65535, 65535, 32'h0,
                                1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, 32'hFFFF_FFFF,
                                1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_FILL, -32768, -32768, 65535, 65535, 32'h5A,
                                1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h0, 1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_COPY, 1024, 0, 1, 1, 32'h0, 1, 0, 0, 0, 0));
      plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, 32'h3, 1, 0, 0, 0, 1));
      plan.push_back(plan_entry(cbf_pkg::OP_COPY, 1023, 767, 2, 2, 32'h0, 1, 0, 0, 0, 0));
      repeat (4)
         plan.push_back(plan_entry(cbf_pkg::OP_PIXEL, 0, 0, 0, 0, $urandom, 0, 0, 0, 0, 0));

      foreach (plan[i]) send_request(plan[i].rq, plan[i].typed, plan[i].rsp);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         idle_mode = p % 3;
         program_frame(p);
         draw_random(PHASE_ITEMS);
      end
      settle();

      if (mismatches == 0 && pending_writes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
